// ===== rtl/core/hco_pkg.sv =====
`default_nettype none
package hco_pkg;

  localparam int CursorSide = 16;
  localparam int PalEntries = 256;
  localparam int CoordW     = $clog2(CursorSide);
  localparam int EnableBit  = 7;
  localparam int ButtonW    = 5;

  localparam logic [7:0] BmpResetVal = 8'hFF;

  typedef enum logic [1:0] {
    CmdRead    = 2'd0,
    CmdWrite   = 2'd1,
    CmdCompose = 2'd2,
    CmdButton  = 2'd3
  } cmd_e;

  localparam logic [3:0] RegXHi    = 4'd0;
  localparam logic [3:0] RegXLo    = 4'd1;
  localparam logic [3:0] RegYHi    = 4'd2;
  localparam logic [3:0] RegYLo    = 4'd3;
  localparam logic [3:0] RegXOfs   = 4'd4;
  localparam logic [3:0] RegYOfs   = 4'd5;
  localparam logic [3:0] RegScroll = 4'd6;
  localparam logic [3:0] RegFlags  = 4'd7;
  localparam logic [3:0] RegBmpIdx = 4'd8;
  localparam logic [3:0] RegBmpDat = 4'd9;
  localparam logic [3:0] RegPalIdx = 4'd10;
  localparam logic [3:0] RegPalHi  = 4'd11;
  localparam logic [3:0] RegPalLo  = 4'd12;

  typedef enum logic [1:0] {
    StIdle,
    StAddr,
    StBmp,
    StPal
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  reg_offset;
    logic [7:0]  write_byte;
    logic [10:0] screen_x;
    logic [10:0] screen_y;
    logic [15:0] under_pixel;
    logic [2:0]  button_number;
    logic        button_pressed;
    logic [1:0]  click_count;
  } req_t;

  typedef struct packed {
    logic capture;
    logic addr_step;
    logic pal_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/hco_chan_if.sv =====
`default_nettype none
interface hco_req_if import hco_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  reg_offset;
  logic [7:0]  write_byte;
  logic [10:0] screen_x;
  logic [10:0] screen_y;
  logic [15:0] under_pixel;
  logic [2:0]  button_number;
  logic        button_pressed;
  logic [1:0]  click_count;

  modport source (
    output valid, command, reg_offset, write_byte, screen_x, screen_y, under_pixel,
           button_number, button_pressed, click_count,
    input  ready
  );
  modport sink (
    input  valid, command, reg_offset, write_byte, screen_x, screen_y, under_pixel,
           button_number, button_pressed, click_count,
    output ready
  );
endinterface

interface hco_rsp_if import hco_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [15:0] composed_pixel;

  modport source (output valid, read_byte, composed_pixel, input ready);
  modport sink (input valid, read_byte, composed_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hco_ctrl.sv =====
`default_nettype none
module hco_ctrl import hco_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (req_valid_i) state_d = StAddr;
      StAddr: state_d = StBmp;
      StBmp:  state_d = StPal;
      StPal:  if (status_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      StAddr: cmd_o.addr_step = 1'b1;
      StBmp:  cmd_o.pal_step = 1'b1;
      // hold the result until the output register frees up
      StPal:  cmd_o.finish = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/hco_dp.sv =====
`default_nettype none
module hco_dp import hco_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     status_o,
  input  wire req_t      req_i,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  output logic [7:0]     read_byte_o,
  output logic [15:0]    composed_pixel_o
);

  function automatic logic [3:0] blend_ch(logic [3:0] u, logic [3:0] c, logic [3:0] a);
    logic [9:0] s;
    s = {6'd0, u} * (10'd16 - {6'd0, a}) + {6'd0, c} * ({6'd0, a} + 10'd1);
    return (s[9:4] > 6'd15) ? 4'hF : s[7:4];
  endfunction

  req_t        req_q;
  logic [15:0] cx_q, cx_d, cy_q, cy_d;
  logic [7:0]  ox_q, ox_d, oy_q, oy_d;
  logic [7:0]  wheel_q, wheel_d, flags_q, flags_d;
  logic [ButtonW-1:0] held_q, held_d;
  logic [7:0]  bptr_q, bptr_d, pptr_q, pptr_d;
  logic        out_valid_q;
  logic [7:0]  rb_q, rb_d;
  logic [15:0] pix_q, pix_d;

  logic        is_compose;
  logic        hit_q, hit_d;
  logic [16:0] posx, posy;
  logic [18:0] hx, vy;
  logic [7:0]  bmp_caddr, bmp_raddr;

  logic [7:0]  bmp_mem [256];
  logic [255:0] bmp_vld_q;
  logic [7:0]  bmp_rd_q;
  logic        bmp_rd_vld_q;
  logic [7:0]  bmp_val;
  logic        bmp_we;

  logic [7:0]  pal_hi_mem [256];
  logic [7:0]  pal_lo_mem [256];
  logic [255:0] pal_vld_q;
  logic [7:0]  pal_hi_rd_q, pal_lo_rd_q;
  logic        pal_rd_vld_q, pal_ok_q;
  logic [7:0]  pal_raddr;
  logic [15:0] pal_val;
  logic        pal_wr_ok, pal_hi_we, pal_lo_we;
  logic        pal_hi_wr, pal_lo_wr;
  logic [7:0]  pal_hi_wdata, pal_lo_wdata;
  logic [3:0]  alpha;
  logic [ButtonW-1:0] btn_mask;

  assign is_compose = (req_q.command == CmdCompose);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  // cursor square hit test
  always_comb begin
    posx  = {cx_q[15], cx_q} + {{9{ox_q[7]}}, ox_q};
    posy  = {cy_q[15], cy_q} + {{9{oy_q[7]}}, oy_q};
    hx    = {8'd0, req_q.screen_x} - {{2{posx[16]}}, posx};
    vy    = {8'd0, req_q.screen_y} - {{2{posy[16]}}, posy};
    hit_d = flags_q[EnableBit] && !hx[18] && !vy[18] &&
            (hx < 19'(CursorSide)) && (vy < 19'(CursorSide));
    bmp_caddr = 8'((32'(vy[CoordW-1:0]) * CursorSide) + 32'(hx[CoordW-1:0]));
    bmp_raddr = is_compose ? bmp_caddr : bptr_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_step) hit_q <= hit_d;
  end

  // bitmap store
  always_ff @(posedge clk_i) begin
    if (bmp_we) bmp_mem[bptr_q] <= req_q.write_byte;
    if (cmd_i.addr_step) begin
      bmp_rd_q     <= bmp_mem[bmp_raddr];
      bmp_rd_vld_q <= bmp_vld_q[bmp_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmp_vld_q <= '0;
    end else if (bmp_we) begin
      bmp_vld_q[bptr_q] <= 1'b1;
    end
  end

  assign bmp_val   = bmp_rd_vld_q ? bmp_rd_q : BmpResetVal;
  assign pal_raddr = is_compose ? bmp_val : pptr_q;

  // first write to an entry clears the other byte lane
  assign pal_hi_wr    = pal_hi_we || (pal_lo_we && !pal_vld_q[pptr_q]);
  assign pal_lo_wr    = pal_lo_we || (pal_hi_we && !pal_vld_q[pptr_q]);
  assign pal_hi_wdata = pal_hi_we ? req_q.write_byte : 8'h00;
  assign pal_lo_wdata = pal_lo_we ? req_q.write_byte : 8'h00;

  // palette store, one array per byte lane
  always_ff @(posedge clk_i) begin
    if (pal_hi_wr) pal_hi_mem[pptr_q] <= pal_hi_wdata;
    if (pal_lo_wr) pal_lo_mem[pptr_q] <= pal_lo_wdata;
    if (cmd_i.pal_step) begin
      pal_hi_rd_q  <= pal_hi_mem[pal_raddr];
      pal_lo_rd_q  <= pal_lo_mem[pal_raddr];
      pal_rd_vld_q <= pal_vld_q[pal_raddr];
      pal_ok_q     <= ({1'b0, pal_raddr} < 9'(PalEntries));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (pal_hi_we || pal_lo_we) begin
      pal_vld_q[pptr_q] <= 1'b1;
    end
  end

  always_comb begin
    pal_val = pal_rd_vld_q ? {pal_hi_rd_q, pal_lo_rd_q} : 16'h0000;
    if (!pal_ok_q) pal_val = '0;
    alpha = pal_val[15:12];
  end

  assign pal_wr_ok = ({1'b0, pptr_q} < 9'(PalEntries));

  // result and register updates
  always_comb begin
    cx_d = cx_q; cy_d = cy_q; ox_d = ox_q; oy_d = oy_q;
    wheel_d = wheel_q; flags_d = flags_q; held_d = held_q;
    bptr_d = bptr_q; pptr_d = pptr_q;
    rb_d = 8'd0; pix_d = 16'd0;
    bmp_we = 1'b0; pal_hi_we = 1'b0; pal_lo_we = 1'b0;
    btn_mask = '0;
    if (req_q.button_number >= 3'd1 && req_q.button_number <= 3'(ButtonW)) begin
      btn_mask = ButtonW'(1) << (req_q.button_number - 3'd1);
    end
    case (req_q.command)
      CmdRead: begin
        unique case (req_q.reg_offset)
          RegXHi:    rb_d = cx_q[15:8];
          RegXLo:    rb_d = cx_q[7:0];
          RegYHi:    rb_d = cy_q[15:8];
          RegYLo:    rb_d = cy_q[7:0];
          RegXOfs:   rb_d = ox_q;
          RegYOfs:   rb_d = oy_q;
          RegScroll: begin
            rb_d    = wheel_q;
            wheel_d = 8'd0;
          end
          RegFlags:  rb_d = flags_q;
          RegBmpIdx: rb_d = bptr_q;
          RegBmpDat: rb_d = bmp_val;
          RegPalIdx: rb_d = pptr_q;
          RegPalHi:  rb_d = pal_val[15:8];
          RegPalLo:  rb_d = pal_val[7:0];
          default:   rb_d = 8'd0;
        endcase
      end
      CmdWrite: begin
        unique case (req_q.reg_offset)
          RegXHi:    cx_d = {req_q.write_byte, cx_q[7:0]};
          RegXLo:    cx_d = {cx_q[15:8], req_q.write_byte};
          RegYHi:    cy_d = {req_q.write_byte, cy_q[7:0]};
          RegYLo:    cy_d = {cy_q[15:8], req_q.write_byte};
          RegXOfs:   ox_d = req_q.write_byte;
          RegYOfs:   oy_d = req_q.write_byte;
          RegScroll: wheel_d = req_q.write_byte;
          RegFlags:  flags_d = req_q.write_byte;
          RegBmpIdx: bptr_d = req_q.write_byte;
          RegBmpDat: bmp_we = cmd_i.finish;
          RegPalIdx: pptr_d = req_q.write_byte;
          RegPalHi:  pal_hi_we = cmd_i.finish && pal_wr_ok;
          RegPalLo:  pal_lo_we = cmd_i.finish && pal_wr_ok;
          default:   ;
        endcase
      end
      CmdCompose: begin
        if (hit_q && alpha != 4'd0) begin
          pix_d = {alpha,
                   blend_ch(req_q.under_pixel[11:8], pal_val[11:8], alpha),
                   blend_ch(req_q.under_pixel[7:4], pal_val[7:4], alpha),
                   blend_ch(req_q.under_pixel[3:0], pal_val[3:0], alpha)};
        end else begin
          pix_d = req_q.under_pixel;
        end
      end
      default: begin
        if (req_q.button_pressed) begin
          held_d  = held_q | btn_mask;
          flags_d = {flags_q[EnableBit], req_q.click_count, held_d};
        end else begin
          held_d  = held_q & ~btn_mask;
          flags_d = {flags_q[EnableBit], 7'd0};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; ox_q <= '0; oy_q <= '0;
      wheel_q <= '0; flags_q <= '0; held_q <= '0;
      bptr_q <= '0; pptr_q <= '0;
    end else if (cmd_i.finish) begin
      cx_q <= cx_d; cy_q <= cy_d; ox_q <= ox_d; oy_q <= oy_d;
      wheel_q <= wheel_d; flags_q <= flags_d; held_q <= held_d;
      bptr_q <= bptr_d; pptr_q <= pptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rb_q  <= rb_d;
      pix_q <= pix_d;
    end
  end

  assign status_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o       = out_valid_q;
  assign read_byte_o       = rb_q;
  assign composed_pixel_o  = pix_q;

endmodule
`default_nettype wire

// ===== rtl/core/hardware_cursor_overlay_registers_top.sv =====
// Hardware mouse cursor: a 16x16 sprite with byte-wide registers.
// req_i carries one request: a register read, a register write, a pixel
// compose or a mouse-button event. rsp_o returns exactly one response per
// request: read_byte for reads, composed_pixel for composes, the other
// field zero (both zero for writes and button events).
// A request is taken while the block is idle. It then passes through the
// hit test and bitmap read, the palette read, and the blend into the
// output register, and the block takes no new request until that request
// has finished; the two registered store reads set that pace.
// The response sits in an output register; the block accepts the next
// request while it waits. If the receiver stalls, a finished second request
// holds in the last step until the register frees up.
// Reset clears the state and the byte registers; the bitmap store reads as
// 0xFF (transparent) and the palette as zero until an entry is written,
// through per-entry valid flags, so no clearing pass is needed.
`default_nettype none
module hardware_cursor_overlay_registers_top import hco_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hco_req_if.sink   req_i,
  hco_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  req_t       req_data;

  assign req_data = '{
    command:        req_i.command,
    reg_offset:     req_i.reg_offset,
    write_byte:     req_i.write_byte,
    screen_x:       req_i.screen_x,
    screen_y:       req_i.screen_y,
    under_pixel:    req_i.under_pixel,
    button_number:  req_i.button_number,
    button_pressed: req_i.button_pressed,
    click_count:    req_i.click_count
  };

  hco_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hco_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .req_i            (req_data),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .read_byte_o      (rsp_o.read_byte),
    .composed_pixel_o (rsp_o.composed_pixel)
  );

  // a response carries read data or a pixel, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.read_byte != 8'd0 |-> rsp_o.composed_pixel == 16'd0)
    else $error("response carries both read data and a pixel");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // no response can complete in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !$rose(rsp_o.valid))
    else $error("response appeared too early");

  // finishing is only allowed when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> status.out_free)
    else $error("result overwrote a pending response");

endmodule
`default_nettype wire
